>>> sv/torus_dimension_order_route_links_defines.svh
// Assertion macros for the torus route-links block.
// Included by the top-level file, which carries the concurrent assertions; no other dependencies.
`ifndef TORUS_DIMENSION_ORDER_ROUTE_LINKS_DEFINES_SVH
`define TORUS_DIMENSION_ORDER_ROUTE_LINKS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDOR_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tdor: implication violated");

// Condition must never be seen out of reset.
`define TDOR_ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tdor: forbidden condition seen");

`endif

>>> sv/tdor_pkg.sv
// Shared types, constants and span helpers for the torus route-links block.
// No dependencies; imported by every module of the block.
package tdor_pkg;

	localparam int MAX_ROWS   = 16;
	localparam int MAX_COLS   = 16;
	localparam int SPAN_N     = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int IDX_W      = $clog2(SPAN_N);
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int GRID_W     = IDX_W + 1;
	localparam int LINK_W     = 16;
	localparam int FIELD_W    = 4;
	localparam int CFG_ADDR_W = 1;
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam logic [CFG_ADDR_W-1:0] CFG_GRID_ROWS = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] CFG_GRID_COLS = 1'b1;

	localparam logic [GRID_W-1:0] GRID_ROWS_RST = GRID_W'(12);
	localparam logic [GRID_W-1:0] GRID_COLS_RST = GRID_W'(10);

	typedef struct packed {
		logic               noc_select;
		logic [FIELD_W-1:0] src_row;
		logic [FIELD_W-1:0] src_col;
		logic [FIELD_W-1:0] dst_row;
		logic [FIELD_W-1:0] dst_col;
		logic               is_multicast;
		logic [FIELD_W-1:0] mcast_first;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] row_index;
		logic [LINK_W-1:0]  first_link_mask;
		logic [LINK_W-1:0]  second_link_mask;
		logic               last;
		logic               bad_coord;
	} rsp_t;

	// Classified request handed from the front to the back.
	typedef struct packed {
		logic               noc;
		logic [FIELD_W-1:0] src_row;
		logic [FIELD_W-1:0] src_col;
		logic [FIELD_W-1:0] dst_row;
		logic [FIELD_W-1:0] dst_col;
		logic [FIELD_W-1:0] t_first;
		logic [FIELD_W-1:0] t_last;
		logic               has_target;
		logic               bad;
	} cmd_t;

	// Positions in cyclic [a, b) below n.
	function automatic logic [SPAN_N-1:0] fwd_span(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b, input logic [GRID_W-1:0] n);
		logic [SPAN_N-1:0] m;
		logic [GRID_W-1:0] iw;
		logic [GRID_W-1:0] aw;
		logic [GRID_W-1:0] bw;
		m  = '0;
		aw = GRID_W'(a);
		bw = GRID_W'(b);
		for (int i = 0; i < SPAN_N; i++) begin
			iw = GRID_W'(i);
			if (aw <= bw) begin
				m[i] = (iw >= aw) && (iw < bw);
			end else begin
				m[i] = ((iw >= aw) && (iw < n)) || (iw < bw);
			end
		end
		return m;
	endfunction

	// Positions in cyclic (e, s] below n: what a decreasing walk from s to e leaves.
	function automatic logic [SPAN_N-1:0] bwd_span(input logic [IDX_W-1:0] e,
			input logic [IDX_W-1:0] s, input logic [GRID_W-1:0] n);
		logic [SPAN_N-1:0] m;
		logic [GRID_W-1:0] iw;
		logic [GRID_W-1:0] ew;
		logic [GRID_W-1:0] sw;
		m  = '0;
		ew = GRID_W'(e);
		sw = GRID_W'(s);
		for (int i = 0; i < SPAN_N; i++) begin
			iw = GRID_W'(i);
			if (ew <= sw) begin
				m[i] = (iw > ew) && (iw <= sw);
			end else begin
				m[i] = (iw <= sw) || ((iw > ew) && (iw < n));
			end
		end
		return m;
	endfunction

endpackage

>>> sv/tdor_front.sv
// Front end: accepts route requests, checks coordinates and classifies targets.
// Depends on tdor_pkg; feeds the command queue.
module tdor_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  tdor_pkg::req_t              req,
	input  logic [tdor_pkg::GRID_W-1:0] rows_eff,
	input  logic [tdor_pkg::GRID_W-1:0] cols_eff,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output tdor_pkg::cmd_t              cmd
);
	import tdor_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;
	logic accept;
	logic [FIELD_W-1:0] end_idx;

	assign full   = valid_s1 && !cmd_ready;
	assign accept = push && !full;

	always_comb begin
		end_idx          = req.noc_select ? req.dst_row : req.dst_col;
		cmd_d.noc        = req.noc_select;
		cmd_d.src_row    = req.src_row;
		cmd_d.src_col    = req.src_col;
		cmd_d.dst_row    = req.dst_row;
		cmd_d.dst_col    = req.dst_col;
		cmd_d.bad        = (GRID_W'(req.src_row) >= rows_eff) ||
				(GRID_W'(req.dst_row) >= rows_eff) ||
				(GRID_W'(req.src_col) >= cols_eff) ||
				(GRID_W'(req.dst_col) >= cols_eff);
		if (req.is_multicast) begin
			cmd_d.t_first    = req.mcast_first;
			cmd_d.t_last     = end_idx;
			cmd_d.has_target = req.mcast_first <= end_idx;
		end else begin
			cmd_d.t_first    = end_idx;
			cmd_d.t_last     = end_idx;
			cmd_d.has_target = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

endmodule

>>> sv/tdor_fifo.sv
// Short command queue between the front end and the route back end.
// Depends on tdor_pkg for the command type and depth.
module tdor_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  tdor_pkg::cmd_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output tdor_pkg::cmd_t rd_data
);
	import tdor_pkg::*;

	cmd_t                  entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign wr_ready = count_q != CMDQ_CNT_W'(CMDQ_DEPTH);
	assign rd_valid = count_q != '0;
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_data  = entry_q[rd_ptr_q];

	function automatic logic [CMDQ_PTR_W-1:0] next_ptr(input logic [CMDQ_PTR_W-1:0] p);
		return (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + CMDQ_PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CMDQ_CNT_W'(1);
				2'b01:   count_q <= count_q - CMDQ_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> sv/tdor_back.sv
// Back end: marks link spans one target per cycle, then scans rows into results.
// Depends on tdor_pkg; drains the command queue and owns the result register.
module tdor_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tdor_pkg::GRID_W-1:0] rows_eff,
	input  logic [tdor_pkg::GRID_W-1:0] cols_eff,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  tdor_pkg::cmd_t              cmd,
	output logic                        empty,
	input  logic                        pop,
	output tdor_pkg::rsp_t              rsp
);
	import tdor_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MARK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam logic [1:0] ST_BAD  = 2'd3;

	logic [1:0]         state_q;
	cmd_t               cur_q;
	logic [FIELD_W-1:0] t_q;
	logic [ROW_W-1:0]   r_q;
	logic               out_valid_q;
	rsp_t               out_q;
	logic [LINK_W-1:0]  first_q  [MAX_ROWS];
	logic [LINK_W-1:0]  second_q [MAX_ROWS];

	logic [LINK_W-1:0]   set_first  [MAX_ROWS];
	logic [LINK_W-1:0]   set_second [MAX_ROWS];
	logic [SPAN_N-1:0]   row_fwd;
	logic [SPAN_N-1:0]   col_fwd;
	logic [SPAN_N-1:0]   row_bwd;
	logic [SPAN_N-1:0]   col_bwd;
	logic [LINK_W-1:0]   t_bit;
	logic [LINK_W-1:0]   sc_bit;
	logic [MAX_ROWS-1:0] nz;
	logic [MAX_ROWS-1:0] upto_r;
	logic                row_last;
	logic                emit_hit;
	logic                slot_free;
	logic                load_cmd;
	logic                load_row;
	logic                load_bad;
	rsp_t                row_rsp;

	assign cmd_ready = state_q == ST_IDLE;
	assign load_cmd  = cmd_ready && cmd_valid;
	assign slot_free = !out_valid_q || pop;

	// Link spans for the current target, taken from the walk endpoints.
	always_comb begin
		row_fwd = fwd_span(IDX_W'(cur_q.src_row), IDX_W'(cur_q.dst_row), rows_eff);
		col_fwd = fwd_span(IDX_W'(cur_q.src_col), IDX_W'(t_q), cols_eff);
		row_bwd = bwd_span(IDX_W'(t_q), IDX_W'(cur_q.src_row), rows_eff);
		col_bwd = bwd_span(IDX_W'(cur_q.dst_col), IDX_W'(cur_q.src_col), cols_eff);
		t_bit   = LINK_W'(1) << t_q;
		sc_bit  = LINK_W'(1) << cur_q.src_col;
		for (int r = 0; r < MAX_ROWS; r++) begin
			if (!cur_q.noc) begin
				set_first[r]  = (ROW_W'(r) == ROW_W'(cur_q.src_row)) ?
						LINK_W'(col_fwd) : '0;
				set_second[r] = row_fwd[r] ? t_bit : '0;
			end else begin
				set_first[r]  = row_bwd[r] ? sc_bit : '0;
				set_second[r] = (ROW_W'(r) == ROW_W'(t_q)) ? LINK_W'(col_bwd) : '0;
			end
		end
	end

	always_comb begin
		for (int r = 0; r < MAX_ROWS; r++) begin
			nz[r] = (first_q[r] != '0) || (second_q[r] != '0);
		end
		upto_r   = (MAX_ROWS'(2) << r_q) - MAX_ROWS'(1);
		row_last = (nz & ~upto_r) == '0;
		emit_hit = nz[r_q] || (nz == '0);
		row_rsp.row_index        = FIELD_W'(r_q);
		row_rsp.first_link_mask  = first_q[r_q];
		row_rsp.second_link_mask = second_q[r_q];
		row_rsp.last             = row_last;
		row_rsp.bad_coord        = 1'b0;
	end

	assign load_row = (state_q == ST_EMIT) && emit_hit && slot_free;
	assign load_bad = (state_q == ST_BAD) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						priority if (cmd.bad) begin
							state_q <= ST_BAD;
						end else if (cmd.has_target) begin
							state_q <= ST_MARK;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_MARK: begin
					if (t_q == cur_q.t_last) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_row && row_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_BAD: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load_row || load_bad) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_cmd) begin
			cur_q <= cmd;
			t_q   <= cmd.t_first;
			r_q   <= '0;
		end else if (state_q == ST_MARK) begin
			t_q <= t_q + FIELD_W'(1);
		end else if ((state_q == ST_EMIT) && (!emit_hit || load_row)) begin
			// advance past empty rows, or past the row just sent
			r_q <= r_q + ROW_W'(1);
		end
		if (load_row) begin
			out_q <= row_rsp;
		end else if (load_bad) begin
			out_q.row_index        <= '0;
			out_q.first_link_mask  <= '0;
			out_q.second_link_mask <= '0;
			out_q.last             <= 1'b1;
			out_q.bad_coord        <= 1'b1;
		end
		for (int r = 0; r < MAX_ROWS; r++) begin
			if (load_cmd) begin
				first_q[r]  <= '0;
				second_q[r] <= '0;
			end else if (state_q == ST_MARK) begin
				first_q[r]  <= first_q[r] | set_first[r];
				second_q[r] <= second_q[r] | set_second[r];
			end
		end
	end

	assign empty = !out_valid_q;
	assign rsp   = out_q;

endmodule

>>> sv/torus_dimension_order_route_links.sv
// Link usage of dimension-order routes on a wrapping 2D mesh. Requests enter through a
// push/full port, are registered in the front end, and wait in a two-entry command queue.
// The back end takes one request at a time: it loads the request, marks link spans one
// route target per cycle (one for unicast, up to sixteen for a multicast range), then
// scans rows one per cycle from row 0 up to the last row with a used link, each result
// waiting for the output register to be free. Bad coordinates give one flagged result.
// Grid size registers are written through cfg_we/cfg_addr/cfg_wdata; the user must write
// them only while idle, as the block itself does not enforce it.
`include "torus_dimension_order_route_links_defines.svh"

module torus_dimension_order_route_links (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tdor_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [tdor_pkg::GRID_W-1:0]     cfg_wdata,
	input  logic                            push,
	output logic                            full,
	input  tdor_pkg::req_t                  req,
	output logic                            empty,
	input  logic                            pop,
	output tdor_pkg::rsp_t                  rsp
);
	import tdor_pkg::*;

	logic [GRID_W-1:0] grid_rows_q;
	logic [GRID_W-1:0] grid_cols_q;
	logic [GRID_W-1:0] rows_eff;
	logic [GRID_W-1:0] cols_eff;
	logic              f_valid;
	logic              f_ready;
	cmd_t              f_cmd;
	logic              q_valid;
	logic              q_ready;
	cmd_t              q_cmd;
	logic              bad_beat;
	logic              good_beat;
	logic              blank_beat;
	logic              bad_shape;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= GRID_ROWS_RST;
			grid_cols_q <= GRID_COLS_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_GRID_ROWS: grid_rows_q <= cfg_wdata;
				CFG_GRID_COLS: grid_cols_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sizes above the mesh maximum act as the maximum.
	assign rows_eff = (grid_rows_q > GRID_W'(MAX_ROWS)) ? GRID_W'(MAX_ROWS) : grid_rows_q;
	assign cols_eff = (grid_cols_q > GRID_W'(MAX_COLS)) ? GRID_W'(MAX_COLS) : grid_cols_q;

	tdor_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.rows_eff  (rows_eff),
		.cols_eff  (cols_eff),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	tdor_fifo u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_cmd),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_cmd)
	);

	tdor_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rows_eff  (rows_eff),
		.cols_eff  (cols_eff),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

	assign bad_beat   = !empty && rsp.bad_coord;
	assign good_beat  = !empty && !rsp.bad_coord;
	assign blank_beat = (rsp.first_link_mask == '0) && (rsp.second_link_mask == '0);
	assign bad_shape  = rsp.last && blank_beat && (rsp.row_index == '0);

	`TDOR_ASSERT_IMPLY(a_bad_rsp_clean, clk, arst_n, bad_beat, bad_shape)
	`TDOR_ASSERT_IMPLY(a_row_in_grid, clk, arst_n, good_beat, GRID_W'(rsp.row_index) < rows_eff)
	`TDOR_ASSERT_NEVER(a_no_blank_mid_row, clk, arst_n, !empty && !rsp.last && blank_beat)
	`TDOR_ASSERT_IMPLY(a_full_needs_push, clk, arst_n, $rose(full), $past(push))

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for torus_dimension_order_route_links: predicts the link rows of
// every accepted route request and compares each popped beat. Depends on tdor_pkg and the RTL.
module testbench;
	import tdor_pkg::*;

	localparam bit NOC_EAST_SOUTH = 1'b0;
	localparam bit NOC_NORTH_WEST = 1'b1;

	localparam int IDLE_SENDER_LIGHT   = 0;
	localparam int IDLE_RECEIVER_LIGHT = 1;
	localparam int IDLE_NONE           = 2;

	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 48;
	localparam int PHASES        = 8;

	class route_link_checker;
		int unsigned         grid_rows;
		int unsigned         grid_cols;
		int unsigned         mismatches;
		rsp_t                expected_rows[$];
		logic [2*LINK_W-1:0] used_links[MAX_ROWS];

		function new();
			grid_rows   = 32'(GRID_ROWS_RST);
			grid_cols   = 32'(GRID_COLS_RST);
			mismatches  = 0;
		endfunction

		function int pending();
			return expected_rows.size();
		endfunction

		function void note_beat(rsp_t b);
			expected_rows.insert(expected_rows.size(), b);
		endfunction

		// Mark every link that one dimension-order walk leaves from.
		function void walk_route(bit noc, int sr, int sc, int er, int ec, int rows, int cols);
			int cr;
			int cc;
			int n;
			cr = sr;
			cc = sc;
			if (noc == NOC_EAST_SOUTH) begin
				for (n = 0; n < MAX_COLS && cc != ec; n++) begin
					used_links[cr][cc] = 1'b1;
					cc = (cc + 1 >= cols) ? 0 : cc + 1;
				end
				for (n = 0; n < MAX_ROWS && cr != er; n++) begin
					used_links[cr][LINK_W + cc] = 1'b1;
					cr = (cr + 1 >= rows) ? 0 : cr + 1;
				end
			end else begin
				for (n = 0; n < MAX_ROWS && cr != er; n++) begin
					used_links[cr][cc] = 1'b1;
					cr = (cr == 0) ? rows - 1 : cr - 1;
				end
				for (n = 0; n < MAX_COLS && cc != ec; n++) begin
					used_links[cr][LINK_W + cc] = 1'b1;
					cc = (cc == 0) ? cols - 1 : cc - 1;
				end
			end
		endfunction

		function void predict_route_links(req_t r);
			int   rows;
			int   cols;
			int   top;
			int   sr;
			int   sc;
			int   dr;
			int   dc;
			rsp_t beat;
			rows = (grid_rows > MAX_ROWS) ? MAX_ROWS : int'(grid_rows);
			cols = (grid_cols > MAX_COLS) ? MAX_COLS : int'(grid_cols);
			sr   = int'(r.src_row);
			sc   = int'(r.src_col);
			dr   = int'(r.dst_row);
			dc   = int'(r.dst_col);
			beat = '0;
			foreach (used_links[i])
				used_links[i] = '0;
			if (sr >= rows || dr >= rows || sc >= cols || dc >= cols) begin
				beat.last      = 1'b1;
				beat.bad_coord = 1'b1;
				note_beat(beat);
				return;
			end
			if (!r.is_multicast) begin
				walk_route(r.noc_select, sr, sc, dr, dc, rows, cols);
			end else if (r.noc_select == NOC_EAST_SOUTH) begin
				for (int t = int'(r.mcast_first); t <= dc; t++)
					walk_route(NOC_EAST_SOUTH, sr, sc, dr, t, rows, cols);
			end else begin
				for (int t = int'(r.mcast_first); t <= dr; t++)
					walk_route(NOC_NORTH_WEST, sr, sc, t, dc, rows, cols);
			end
			top = -1;
			for (int i = 0; i < rows; i++)
				if (used_links[i] != '0)
					top = i;
			// empty route: one beat with empty masks and last set
			if (top < 0) begin
				beat.last = 1'b1;
				note_beat(beat);
				return;
			end
			for (int i = 0; i <= top; i++) begin
				if (used_links[i] != '0) begin
					beat.row_index        = FIELD_W'(i);
					beat.first_link_mask  = used_links[i][LINK_W-1:0];
					beat.second_link_mask = used_links[i][2*LINK_W-1:LINK_W];
					beat.last             = (i == top);
					beat.bad_coord        = 1'b0;
					note_beat(beat);
				end
			end
		endfunction

		task report(string msg);
			mismatches++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_row(rsp_t got);
			rsp_t want;
			if (expected_rows.size() == 0) begin
				report($sformatf("unexpected beat, row %0d", got.row_index));
				return;
			end
			want = expected_rows.pop_front();
			if (got.row_index !== want.row_index)
				report($sformatf("row_index %0d, want %0d", got.row_index, want.row_index));
			if (got.first_link_mask !== want.first_link_mask)
				report($sformatf("row %0d first_link_mask %h, want %h", want.row_index,
					got.first_link_mask, want.first_link_mask));
			if (got.second_link_mask !== want.second_link_mask)
				report($sformatf("row %0d second_link_mask %h, want %h", want.row_index,
					got.second_link_mask, want.second_link_mask));
			if (got.last !== want.last)
				report($sformatf("row %0d last %b, want %b", want.row_index, got.last, want.last));
			if (got.bad_coord !== want.bad_coord)
				report($sformatf("row %0d bad_coord %b, want %b", want.row_index,
					got.bad_coord, want.bad_coord));
		endtask
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_GRID_ROWS;
	logic [GRID_W-1:0]     cfg_wdata = '0;
	logic                  push      = 1'b0;
	logic                  full;
	req_t                  req       = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	rsp_t                  rsp;

	route_link_checker links = new();
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	int                stall_cycles  = 0;

	int ph_rows  [PHASES] = '{16, 1, 5, 16, 1, 0, 31, 12};
	int ph_cols  [PHASES] = '{16, 1, 7, 1, 16, 31, 3, 10};
	int ph_items [PHASES] = '{55, 15, 45, 30, 30, 10, 40, 75};
	int ph_idle  [PHASES] = '{IDLE_SENDER_LIGHT, IDLE_SENDER_LIGHT, IDLE_SENDER_LIGHT,
		IDLE_RECEIVER_LIGHT, IDLE_RECEIVER_LIGHT, IDLE_RECEIVER_LIGHT, IDLE_NONE, IDLE_NONE};

	torus_dimension_order_route_links i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	// Sample both handshakes at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (push && !full)
				links.predict_route_links(req);
			if (pop && !empty)
				links.check_row(rsp);
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		forever begin
			@(negedge clk);
			pop = arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic req_t make_req(bit noc, int sr, int sc, int dr, int dc, int mc, int first);
		req_t r;
		r.noc_select   = noc;
		r.src_row      = FIELD_W'(sr);
		r.src_col      = FIELD_W'(sc);
		r.dst_row      = FIELD_W'(dr);
		r.dst_col      = FIELD_W'(dc);
		r.is_multicast = (mc != 0);
		r.mcast_first  = FIELD_W'(first);
		return r;
	endfunction

	// Mostly in-grid coordinates; now and then anything the field holds.
	function automatic int pick_coord(int limit);
		if (limit == 0 || $urandom_range(99) < 6)
			return int'($urandom_range(15));
		return int'($urandom_range(limit - 1));
	endfunction

	function automatic req_t random_request(int rows, int cols);
		req_t r;
		int   end_index;
		r.noc_select   = 1'($urandom_range(1));
		r.src_row      = FIELD_W'(pick_coord(rows));
		r.src_col      = FIELD_W'(pick_coord(cols));
		r.dst_row      = FIELD_W'(pick_coord(rows));
		r.dst_col      = FIELD_W'(pick_coord(cols));
		r.is_multicast = ($urandom_range(99) < 40);
		end_index      = (r.noc_select == NOC_EAST_SOUTH) ? int'(r.dst_col) : int'(r.dst_row);
		r.mcast_first  = ($urandom_range(99) < 80) ? FIELD_W'($urandom_range(end_index)) :
			FIELD_W'($urandom_range(15));
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the accepting beat.
	task automatic push_request(req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		req  = r;
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
	endtask

	// Hold off until every expected beat has been popped.
	task automatic settle();
		push = 1'b0;
		while (links.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic program_grid(int rows, int cols);
		cfg_we    = 1'b1;
		cfg_addr  = CFG_GRID_ROWS;
		cfg_wdata = GRID_W'(rows);
		@(negedge clk);
		cfg_addr  = CFG_GRID_COLS;
		cfg_wdata = GRID_W'(cols);
		@(negedge clk);
		cfg_we    = 1'b0;
		links.grid_rows = unsigned'(rows);
		links.grid_cols = unsigned'(cols);
	endtask

	task automatic set_idling(int mode);
		case (mode)
			IDLE_SENDER_LIGHT: begin
				send_idle_pct = 26;
				recv_idle_pct = 70;
			end
			IDLE_RECEIVER_LIGHT: begin
				send_idle_pct = 70;
				recv_idle_pct = 26;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	initial begin
		int eff_rows;
		int eff_cols;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed beats at the reset grid of 12 rows by 10 columns.
		set_idling(IDLE_SENDER_LIGHT);
		push_request(make_req(NOC_EAST_SOUTH, 0, 0, 11, 9, 0, 0));
		push_request(make_req(NOC_NORTH_WEST, 0, 0, 11, 9, 0, 0));
		push_request(make_req(NOC_EAST_SOUTH, 11, 9, 0, 0, 0, 0));
		push_request(make_req(NOC_NORTH_WEST, 11, 9, 0, 0, 0, 0));
		push_request(make_req(NOC_EAST_SOUTH, 5, 5, 5, 5, 0, 0));
		push_request(make_req(NOC_NORTH_WEST, 3, 4, 3, 4, 0, 0));
		push_request(make_req(NOC_EAST_SOUTH, 2, 3, 7, 9, 1, 0));
		push_request(make_req(NOC_NORTH_WEST, 2, 3, 11, 7, 1, 0));
		push_request(make_req(NOC_EAST_SOUTH, 2, 3, 7, 4, 1, 9));
		push_request(make_req(NOC_NORTH_WEST, 2, 3, 0, 7, 1, 11));
		push_request(make_req(NOC_EAST_SOUTH, 12, 3, 7, 4, 1, 9));
		push_request(make_req(NOC_NORTH_WEST, 12, 0, 0, 0, 0, 0));
		push_request(make_req(NOC_EAST_SOUTH, 0, 10, 0, 0, 0, 0));
		push_request(make_req(NOC_EAST_SOUTH, 0, 0, 15, 0, 0, 0));
		push_request(make_req(NOC_NORTH_WEST, 0, 0, 0, 15, 0, 0));
		push_request(make_req(NOC_NORTH_WEST, 15, 15, 15, 15, 1, 15));
		push_request(make_req(NOC_EAST_SOUTH, 0, 0, 0, 0, 0, 0));
		push_request(make_req(NOC_EAST_SOUTH, 4, 8, 1, 6, 1, 6));
		push_request(make_req(NOC_NORTH_WEST, 6, 2, 11, 1, 1, 15));

		for (int p = 0; p < PHASES; p++) begin
			settle();
			program_grid(ph_rows[p], ph_cols[p]);
			set_idling(ph_idle[p]);
			eff_rows = (ph_rows[p] > MAX_ROWS) ? MAX_ROWS : ph_rows[p];
			eff_cols = (ph_cols[p] > MAX_COLS) ? MAX_COLS : ph_cols[p];
			if (p == 0) begin
				push_request(make_req(NOC_EAST_SOUTH, 15, 15, 15, 15, 1, 15));
				push_request(make_req(NOC_EAST_SOUTH, 0, 0, 15, 15, 1, 0));
				push_request(make_req(NOC_NORTH_WEST, 0, 15, 15, 0, 1, 0));
			end
			for (int i = 0; i < ph_items[p]; i++) begin
				if (p == 0 && i == ph_items[p] / 2)
					settle();
				push_request(random_request(eff_rows, eff_cols));
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (links.pending() != 0)
			links.report($sformatf("%0d expected beats never arrived", links.pending()));
		if (links.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
